/* design/erbd_pkg.sv */
// Package for the edge row band detector: payload structs, register indexes,
// size limits and reset values. No dependencies.
`default_nettype none
package erbd_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned SIZE_CAP   = 4096;
  localparam int unsigned WIDTH_LIM  = (MAX_WIDTH  > SIZE_CAP) ? SIZE_CAP : MAX_WIDTH;
  localparam int unsigned HEIGHT_LIM = (MAX_HEIGHT > SIZE_CAP) ? SIZE_CAP : MAX_HEIGHT;

  localparam int unsigned CFG_W  = 13;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned PIX_W  = 8;

  localparam logic [CFG_W-1:0] WIDTH_MAX_C  = CFG_W'(WIDTH_LIM);
  localparam logic [CFG_W-1:0] HEIGHT_MAX_C = CFG_W'(HEIGHT_LIM);
  localparam logic [CFG_W-1:0] SIZE_MIN_C   = CFG_W'(3);

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = CFG_W'(420);
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = CFG_W'(295);
  localparam logic [CFG_W-1:0] RST_MIN_EDGES    = CFG_W'(8);
  localparam logic [CFG_W-1:0] RST_MIN_ROWS     = CFG_W'(12);

  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MIN_EDGES    = 2'd2,
    REG_MIN_ROWS     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic             diff_valid;
    logic [POS_W-1:0] diff_row;
    logic [POS_W-1:0] diff_col;
    logic [PIX_W-1:0] diff_value;
    logic             frame_done;
    logic [POS_W-1:0] band_first;
    logic [CNT_W-1:0] band_count;
  } out_item_t;

endpackage
`default_nettype wire

/* design/edge_row_band_detector_unit.sv */
// Top level of the edge row band detector: per-pixel horizontal difference,
// row edge count and band run tracking. Depends on erbd_pkg.
`default_nettype none
// Takes one pixel per clock in raster order while in_ready is high and returns one
// result per pixel. All per-pixel work (difference, row count, run and band update)
// happens at the accepting edge: one item per cycle while out_ready holds. A result
// is registered in the output register, or in the skid register while that is held;
// the skid keeps in_ready independent of out_ready, and in_ready drops only while two
// results wait. Configuration writes take effect at once and belong between frames.
module edge_row_band_detector_unit
  import erbd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] frame_width_r, frame_height_r, min_edges_r, min_rows_r;

  logic [POS_W-1:0] col_r, row_r, run_first_r, band_start_r;
  logic [PIX_W-1:0] prev_pixel_r;
  logic [CNT_W-1:0] edge_cnt_r, run_len_r, band_len_r;

  logic [POS_W-1:0] col_nxt, row_nxt, run_first_nxt, band_start_nxt;
  logic [CNT_W-1:0] edge_cnt_nxt, run_len_nxt, band_len_nxt;

  out_item_t res;
  out_item_t out_data_r, skid_data_r;
  logic      out_valid_r, skid_valid_r;
  logic      accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      min_edges_r    <= RST_MIN_EDGES;
      min_rows_r     <= RST_MIN_ROWS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        REG_MIN_EDGES:    min_edges_r    <= cfg_wdata;
        REG_MIN_ROWS:     min_rows_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [CFG_W-1:0] w, h;
    logic [POS_W-1:0] c, r, rf, bs;
    logic [CNT_W-1:0] ec, rl, bl;
    logic [CFG_W+1:0] c_ext, r_ext;
    logic             inner, row_end, last_row, dval;
    logic [PIX_W-1:0] dv;

    w = frame_width_r;
    if (frame_width_r < SIZE_MIN_C) w = SIZE_MIN_C;
    else if (frame_width_r > WIDTH_MAX_C) w = WIDTH_MAX_C;
    h = frame_height_r;
    if (frame_height_r < SIZE_MIN_C) h = SIZE_MIN_C;
    else if (frame_height_r > HEIGHT_MAX_C) h = HEIGHT_MAX_C;

    if (in_data.frame_start) begin
      c = '0; r = '0; ec = '0; rf = '0; rl = '0; bs = '0; bl = '0;
    end else begin
      c = col_r; r = row_r; ec = edge_cnt_r; rf = run_first_r; rl = run_len_r;
      bs = band_start_r; bl = band_len_r;
    end

    c_ext    = (CFG_W+2)'(c);
    r_ext    = (CFG_W+2)'(r);
    inner    = (r != '0) && ((r_ext + 2) <= (CFG_W+2)'(h));
    row_end  = (c_ext + 1) >= (CFG_W+2)'(w);
    last_row = (r_ext + 1) >= (CFG_W+2)'(h);
    dval     = inner && (c >= POS_W'(2)) && ((c_ext + 1) <= (CFG_W+2)'(w));
    dv       = (prev_pixel_r > in_data.pixel) ? (prev_pixel_r - in_data.pixel)
                                              : (in_data.pixel - prev_pixel_r);

    res = '0;
    if (dval) begin
      res.diff_valid = 1'b1;
      res.diff_row   = r;
      res.diff_col   = c - POS_W'(1);
      res.diff_value = dv;
      if (dv != '0 && ec != CNT_SAT) ec = ec + CNT_W'(1);
    end

    col_nxt = c + POS_W'(1);
    row_nxt = r;
    if (row_end) begin
      if (inner) begin
        if (ec >= min_edges_r) begin
          if (rl == '0) rf = r;
          if (rl != CNT_SAT) rl = rl + CNT_W'(1);
        end else begin
          if (rl > min_rows_r) begin
            bs = rf;
            bl = rl;
          end
          rl = '0;
          rf = '0;
        end
      end
      ec = '0;
      col_nxt = '0;
      if (last_row) begin
        res.frame_done = 1'b1;
        res.band_first = bs;
        res.band_count = bl;
        row_nxt = '0; rf = '0; rl = '0; bs = '0; bl = '0;
      end else begin
        row_nxt = r + POS_W'(1);
      end
    end

    edge_cnt_nxt   = ec;
    run_first_nxt  = rf;
    run_len_nxt    = rl;
    band_start_nxt = bs;
    band_len_nxt   = bl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      prev_pixel_r <= '0;
      edge_cnt_r   <= '0;
      run_first_r  <= '0;
      run_len_r    <= '0;
      band_start_r <= '0;
      band_len_r   <= '0;
    end else if (accept) begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      prev_pixel_r <= in_data.pixel;
      edge_cnt_r   <= edge_cnt_nxt;
      run_first_r  <= run_first_nxt;
      run_len_r    <= run_len_nxt;
      band_start_r <= band_start_nxt;
      band_len_r   <= band_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (accept) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
